// ----- design/astc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the alarm set and trigger controller: beat types, command
// and register codes, reset values. No dependencies.
package astc_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_CW    = 2'd1,
		CMD_CCW   = 2'd2,
		CMD_PRESS = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		FLD_HOUR   = 2'd0,
		FLD_MINUTE = 2'd1,
		FLD_PM     = 2'd2,
		FLD_ARMED  = 2'd3
	} field_t;

	typedef enum logic [1:0] {
		REG_SET_TIMEOUT = 2'd0,
		REG_LOCKOUT     = 2'd1,
		REG_RESTART     = 2'd2
	} reg_idx_t;

	localparam int TIMEOUT_W = 16;
	localparam int LOCKOUT_W = 17;
	localparam int RESTART_W = 12;
	localparam int CFG_W     = 17;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd10000;
	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = 17'd60000;
	localparam logic [RESTART_W-1:0] RESTART_RST = 12'd501;

	localparam logic [3:0] HOUR12_MAX = 4'd12;
	localparam logic [3:0] HOUR12_MIN = 4'd1;
	localparam logic [5:0] MINUTE_MAX = 6'd59;
	localparam logic [4:0] HOURS_HALF = 5'd12;
	localparam logic [4:0] HOURS_DAY  = 5'd24;

	typedef struct packed {
		cmd_t       command;
		logic [4:0] clock_hour;
		logic [5:0] clock_minute;
	} in_beat_t;

	typedef struct packed {
		logic       sounding;
		logic       play_start;
		logic       play_stop;
		logic       in_set_mode;
		logic [1:0] edit_field;
		logic [3:0] shown_hour;
		logic [5:0] shown_minute;
		logic       shown_pm;
		logic       shown_armed;
	} out_beat_t;

	// 24-hour value (any 5-bit code) to 12-hour display form
	function automatic logic [3:0] hour12(input logic [4:0] h24);
		logic [4:0] r;
		begin
			if (h24 >= HOURS_DAY)
				r = h24 - HOURS_DAY;
			else if (h24 >= HOURS_HALF)
				r = h24 - HOURS_HALF;
			else
				r = h24;
			hour12 = (r == 5'd0) ? HOUR12_MAX : r[3:0];
		end
	endfunction

endpackage

// ----- design/alarm_set_and_trigger_controller_core.sv -----
`timescale 1ns / 1ps
// Top level of the alarm set and trigger controller: input stage, event
// logic on the alarm state, result register. Depends on astc_pkg.

// One event beat in, one result beat out. An event is captured in the
// input stage; when it advances, the whole event update (set mode
// edits, timeout and lockout counters, match compare) runs in one pass and
// writes the result register, so one event is taken every cycle unless a
// result waits on out_ready. The input stage keeps filling while a result
// waits on out_ready, so one event is held back before in_ready drops.
// Configuration writes are taken at any time
// (cfg_ready is tied high); write them only while no event is in flight.
module alarm_set_and_trigger_controller_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  astc_pkg::in_beat_t       in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output astc_pkg::out_beat_t      out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [astc_pkg::CFG_W-1:0] cfg_data
);

	logic [astc_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [astc_pkg::LOCKOUT_W-1:0] lockout_q;
	logic [astc_pkg::RESTART_W-1:0] restart_q;

	logic                 valid_s1;
	astc_pkg::in_beat_t   in_s1;
	logic                 valid_s2;
	astc_pkg::out_beat_t  out_s2;

	logic       editing_q, editing_d;
	logic [1:0] field_q, field_d;
	logic [3:0] ehour_q, ehour_d;
	logic [5:0] emin_q, emin_d;
	logic       epm_q, epm_d;
	logic       earmed_q, earmed_d;
	logic [astc_pkg::TIMEOUT_W-1:0] idle_q, idle_d;
	logic [4:0] ahour_q, ahour_d;
	logic [5:0] amin_q, amin_d;
	logic       aarmed_q, aarmed_d;
	logic       sound_q, sound_d;
	logic [astc_pkg::LOCKOUT_W-1:0] since_q, since_d;
	logic       restarted_q, restarted_d;
	logic       start, stop;
	logic       advance;
	logic [astc_pkg::TIMEOUT_W-1:0] idle_inc;
	logic [astc_pkg::LOCKOUT_W-1:0] since_inc;
	logic [4:0] commit_h;
	logic       knob_up;
	astc_pkg::out_beat_t res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= astc_pkg::TIMEOUT_RST;
			lockout_q <= astc_pkg::LOCKOUT_RST;
			restart_q <= astc_pkg::RESTART_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				astc_pkg::REG_SET_TIMEOUT: timeout_q <= cfg_data[astc_pkg::TIMEOUT_W-1:0];
				astc_pkg::REG_LOCKOUT:     lockout_q <= cfg_data[astc_pkg::LOCKOUT_W-1:0];
				astc_pkg::REG_RESTART:     restart_q <= cfg_data[astc_pkg::RESTART_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// event update
	always_comb begin
		editing_d   = editing_q;
		field_d     = field_q;
		ehour_d     = ehour_q;
		emin_d      = emin_q;
		epm_d       = epm_q;
		earmed_d    = earmed_q;
		idle_d      = idle_q;
		ahour_d     = ahour_q;
		amin_d      = amin_q;
		aarmed_d    = aarmed_q;
		sound_d     = sound_q;
		since_d     = since_q;
		restarted_d = restarted_q;
		start       = 1'b0;
		stop        = 1'b0;
		knob_up     = (in_s1.command == astc_pkg::CMD_CW);
		idle_inc    = (idle_q != '1) ? idle_q + 1'b1 : idle_q;
		since_inc   = (since_q != '1) ? since_q + 1'b1 : since_q;
		commit_h    = {1'b0, ehour_q};
		if (epm_q)
			commit_h = commit_h + astc_pkg::HOURS_HALF;
		else if (commit_h == astc_pkg::HOURS_HALF)
			commit_h = 5'd0;
		if (commit_h == astc_pkg::HOURS_DAY)
			commit_h = astc_pkg::HOURS_HALF;

		unique case (in_s1.command)
			astc_pkg::CMD_TICK: begin
				if (editing_q) begin
					idle_d = idle_inc;
					if (idle_inc > timeout_q)
						editing_d = 1'b0;
				end
				since_d = since_inc;
				if (sound_q) begin
					if (since_inc > {{(astc_pkg::LOCKOUT_W-astc_pkg::RESTART_W){1'b0}}, restart_q}
					    && !restarted_q) begin
						restarted_d = 1'b1;
						start       = 1'b1;
					end
				end else if (aarmed_q && since_inc > lockout_q &&
				             in_s1.clock_hour == ahour_q && in_s1.clock_minute == amin_q) begin
					sound_d     = 1'b1;
					since_d     = '0;
					restarted_d = 1'b0;
					start       = 1'b1;
				end
			end
			astc_pkg::CMD_CW, astc_pkg::CMD_CCW: begin
				if (editing_q) begin
					idle_d = '0;
					case (field_q)
						astc_pkg::FLD_HOUR: begin
							if (knob_up)
								ehour_d = (ehour_q != astc_pkg::HOUR12_MAX) ?
								          ehour_q + 1'b1 : astc_pkg::HOUR12_MIN;
							else
								ehour_d = (ehour_q != astc_pkg::HOUR12_MIN) ?
								          ehour_q - 1'b1 : astc_pkg::HOUR12_MAX;
						end
						astc_pkg::FLD_MINUTE: begin
							if (knob_up)
								emin_d = (emin_q != astc_pkg::MINUTE_MAX) ? emin_q + 1'b1 : 6'd0;
							else
								emin_d = (emin_q != 6'd0) ? emin_q - 1'b1 : astc_pkg::MINUTE_MAX;
						end
						astc_pkg::FLD_PM: epm_d = !epm_q;
						default:          earmed_d = !earmed_q;
					endcase
				end
			end
			default: begin
				if (sound_q) begin
					sound_d = 1'b0;
					stop    = 1'b1;
				end else if (!editing_q) begin
					editing_d = 1'b1;
					idle_d    = '0;
					field_d   = astc_pkg::FLD_HOUR;
					ehour_d   = astc_pkg::hour12(ahour_q);
					emin_d    = amin_q;
					epm_d     = (ahour_q >= astc_pkg::HOURS_HALF);
					earmed_d  = aarmed_q;
				end else if (field_q != astc_pkg::FLD_ARMED) begin
					idle_d  = '0;
					field_d = field_q + 1'b1;
				end else begin
					ahour_d   = commit_h;
					amin_d    = emin_q;
					aarmed_d  = earmed_q;
					idle_d    = '0;
					editing_d = 1'b0;
				end
			end
		endcase
	end

	always_comb begin
		res.sounding    = sound_d;
		res.play_start  = start;
		res.play_stop   = stop;
		res.in_set_mode = editing_d;
		res.edit_field  = field_d;
		if (editing_d) begin
			res.shown_hour   = ehour_d;
			res.shown_minute = emin_d;
			res.shown_pm     = epm_d;
			res.shown_armed  = earmed_d;
		end else begin
			res.shown_hour   = astc_pkg::hour12(ahour_d);
			res.shown_minute = amin_d;
			res.shown_pm     = (ahour_d >= astc_pkg::HOURS_HALF);
			res.shown_armed  = aarmed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			editing_q   <= 1'b0;
			field_q     <= astc_pkg::FLD_HOUR;
			ehour_q     <= astc_pkg::HOUR12_MAX;
			emin_q      <= '0;
			epm_q       <= 1'b0;
			earmed_q    <= 1'b0;
			idle_q      <= '0;
			ahour_q     <= '0;
			amin_q      <= '0;
			aarmed_q    <= 1'b0;
			sound_q     <= 1'b0;
			since_q     <= '0;
			restarted_q <= 1'b1;
		end else if (advance) begin
			editing_q   <= editing_d;
			field_q     <= field_d;
			ehour_q     <= ehour_d;
			emin_q      <= emin_d;
			epm_q       <= epm_d;
			earmed_q    <= earmed_d;
			idle_q      <= idle_d;
			ahour_q     <= ahour_d;
			amin_q      <= amin_d;
			aarmed_q    <= aarmed_d;
			sound_q     <= sound_d;
			since_q     <= since_d;
			restarted_q <= restarted_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= res;
		end
	end

	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.play_start && out_data.play_stop))
		else $error("start and stop pulses in one beat");

	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.play_stop |-> !out_data.sounding)
		else $error("stop pulse while still sounding");

	a_start_sound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.play_start |-> out_data.sounding)
		else $error("start pulse while not sounding");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(in_s1))
		else $error("input stage lost a stalled event");

	a_rose_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sound_q) |-> since_q == '0 && !restarted_q)
		else $error("sounding started without clearing its counter");

endmodule

// ----- test/tb_alarm_set_and_trigger_controller_core.sv -----
`timescale 1ns / 1ps
// Testbench for alarm_set_and_trigger_controller_core: a shadow of the alarm
// state predicts every result beat, tasks drive event and register beats.
// Depends on astc_pkg and the core.

// Shadow copy of the controller state; one expected beat per accepted event.
class alarm_shadow;
	logic [15:0] timeout_lim;
	logic [16:0] lockout_lim;
	logic [11:0] restart_lim;

	logic               in_edit;
	astc_pkg::field_t   edit_sel;
	logic [3:0]  e_hour;
	logic [5:0]  e_min;
	logic        e_pm;
	logic        e_armed;
	logic [15:0] idle_cnt;
	logic [4:0]  al_hour;
	logic [5:0]  al_min;
	logic        al_armed;
	logic        ringing;
	logic [16:0] since_ring;
	logic        restart_done;

	astc_pkg::out_beat_t due_beats[$];
	int unsigned errors, seen, fires, restarts, stops, commits, timeouts;

	function new();
		timeout_lim  = 16'd10000;
		lockout_lim  = 17'd60000;
		restart_lim  = 12'd501;
		in_edit      = 1'b0;
		edit_sel     = astc_pkg::FLD_HOUR;
		e_hour       = 4'd12;
		e_min        = 6'd0;
		e_pm         = 1'b0;
		e_armed      = 1'b0;
		idle_cnt     = 16'd0;
		al_hour      = 5'd0;
		al_min       = 6'd0;
		al_armed     = 1'b0;
		ringing      = 1'b0;
		since_ring   = 17'd0;
		restart_done = 1'b1;
		errors = 0; seen = 0; fires = 0; restarts = 0;
		stops = 0; commits = 0; timeouts = 0;
	endfunction

	function void set_reg(astc_pkg::reg_idx_t idx, logic [16:0] v);
		case (idx)
			astc_pkg::REG_SET_TIMEOUT: timeout_lim = v[15:0];
			astc_pkg::REG_LOCKOUT:     lockout_lim = v;
			astc_pkg::REG_RESTART:     restart_lim = v[11:0];
			default: ;
		endcase
	endfunction

	function logic [3:0] to_12h(logic [4:0] h);
		logic [4:0] r;
		r = h % 5'd12;
		return (r == 5'd0) ? 4'd12 : r[3:0];
	endfunction

	function void turn(bit up);
		if (!in_edit)
			return;
		idle_cnt = 16'd0;
		case (edit_sel)
			astc_pkg::FLD_HOUR: begin
				if (up)
					e_hour = (e_hour != 4'd12) ? e_hour + 4'd1 : 4'd1;
				else
					e_hour = (e_hour != 4'd1) ? e_hour - 4'd1 : 4'd12;
			end
			astc_pkg::FLD_MINUTE: begin
				if (up)
					e_min = (e_min != 6'd59) ? e_min + 6'd1 : 6'd0;
				else
					e_min = (e_min != 6'd0) ? e_min - 6'd1 : 6'd59;
			end
			astc_pkg::FLD_PM: e_pm = !e_pm;
			default:          e_armed = !e_armed;
		endcase
	endfunction

	function void take_event(astc_pkg::in_beat_t b);
		astc_pkg::out_beat_t r;
		logic       start, stop;
		logic [4:0] h;
		start = 1'b0;
		stop  = 1'b0;
		case (b.command)
			astc_pkg::CMD_TICK: begin
				if (in_edit) begin
					if (idle_cnt != 16'hFFFF)
						idle_cnt = idle_cnt + 16'd1;
					if (idle_cnt > timeout_lim) begin
						in_edit = 1'b0;
						timeouts++;
					end
				end
				if (since_ring != 17'h1FFFF)
					since_ring = since_ring + 17'd1;
				if (ringing) begin
					if (since_ring > restart_lim && !restart_done) begin
						restart_done = 1'b1;
						start = 1'b1;
						restarts++;
					end
				end else if (al_armed && since_ring > lockout_lim &&
				             b.clock_hour == al_hour && b.clock_minute == al_min) begin
					ringing      = 1'b1;
					since_ring   = 17'd0;
					restart_done = 1'b0;
					start        = 1'b1;
					fires++;
				end
			end
			astc_pkg::CMD_CW:  turn(1'b1);
			astc_pkg::CMD_CCW: turn(1'b0);
			default: begin
				if (ringing) begin
					ringing = 1'b0;
					stop = 1'b1;
					stops++;
				end else if (!in_edit) begin
					in_edit  = 1'b1;
					idle_cnt = 16'd0;
					edit_sel = astc_pkg::FLD_HOUR;
					e_hour   = to_12h(al_hour);
					e_min    = al_min;
					e_pm     = (al_hour >= 5'd12);
					e_armed  = al_armed;
				end else if (edit_sel != astc_pkg::FLD_ARMED) begin
					idle_cnt = 16'd0;
					edit_sel = astc_pkg::field_t'(edit_sel + 2'd1);
				end else begin
					// 12 am is hour 0, 12 pm stays 12
					h = {1'b0, e_hour};
					if (e_pm)
						h = h + 5'd12;
					else if (h == 5'd12)
						h = 5'd0;
					if (h == 5'd24)
						h = 5'd12;
					al_hour  = h;
					al_min   = e_min;
					al_armed = e_armed;
					idle_cnt = 16'd0;
					in_edit  = 1'b0;
					commits++;
				end
			end
		endcase
		r.sounding    = ringing;
		r.play_start  = start;
		r.play_stop   = stop;
		r.in_set_mode = in_edit;
		r.edit_field  = edit_sel;
		if (in_edit) begin
			r.shown_hour   = e_hour;
			r.shown_minute = e_min;
			r.shown_pm     = e_pm;
			r.shown_armed  = e_armed;
		end else begin
			r.shown_hour   = to_12h(al_hour);
			r.shown_minute = al_min;
			r.shown_pm     = (al_hour >= 5'd12);
			r.shown_armed  = al_armed;
		end
		due_beats.push_back(r);
	endfunction

	function void check_display(astc_pkg::out_beat_t got);
		astc_pkg::out_beat_t want;
		seen++;
		if (due_beats.size() == 0) begin
			errors++;
			$display("%0t: result beat with nothing expected, expected none got %h",
			         $time, got);
			return;
		end
		want = due_beats.pop_front();
		if (got !== want) begin
			errors++;
			$display("%0t: result beat mismatch, expected %h got %h", $time, want, got);
		end
	endfunction

	function int pending();
		return due_beats.size();
	endfunction
endclass

module tb_alarm_set_and_trigger_controller_core;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	astc_pkg::in_beat_t         in_data = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	astc_pkg::out_beat_t        out_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index = '0;
	logic [astc_pkg::CFG_W-1:0] cfg_data = '0;

	alarm_shadow shadow = new();
	bit          calm = 1'b0;
	int unsigned phase_items;
	int unsigned events_sent = 0;

	alarm_set_and_trigger_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.check_display(out_data);
	end

	initial begin
		#10000000;
		$display("tb_alarm_set_and_trigger_controller_core NOT OK");
		$finish;
	end

	function automatic astc_pkg::in_beat_t mk(astc_pkg::cmd_t c, logic [4:0] h,
	                                          logic [5:0] m);
		astc_pkg::in_beat_t b;
		b.command      = c;
		b.clock_hour   = h;
		b.clock_minute = m;
		return b;
	endfunction

	function automatic astc_pkg::in_beat_t any_beat(astc_pkg::cmd_t c);
		return mk(c, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
	endfunction

	// ticks lean toward the stored alarm time so matches actually happen
	function automatic astc_pkg::in_beat_t tick_beat();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return mk(astc_pkg::CMD_TICK, shadow.al_hour, shadow.al_min);
		else if (p < 70)
			return mk(astc_pkg::CMD_TICK, shadow.al_hour, shadow.al_min + 6'd1);
		return any_beat(astc_pkg::CMD_TICK);
	endfunction

	function automatic astc_pkg::cmd_t knob_dir();
		return ($urandom_range(0, 1) == 0) ? astc_pkg::CMD_CW : astc_pkg::CMD_CCW;
	endfunction

	// Entered just after a falling edge, returns just after a falling edge.
	task automatic push_event(input astc_pkg::in_beat_t b);
		bit ignored;
		while (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ignored = (b.command == astc_pkg::CMD_CW || b.command == astc_pkg::CMD_CCW) &&
		          !shadow.in_edit;
		shadow.take_event(b);
		events_sent++;
		if (!ignored)
			phase_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input astc_pkg::reg_idx_t idx, input logic [16:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [16:0] tmo, input logic [16:0] lock,
	                        input logic [16:0] rst);
		drain();
		write_reg(astc_pkg::REG_SET_TIMEOUT, tmo);
		write_reg(astc_pkg::REG_LOCKOUT, lock);
		write_reg(astc_pkg::REG_RESTART, rst);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// press in, knob each field, press on; commits after the armed field
	task automatic set_sequence(input bit force_arm);
		int n;
		push_event(any_beat(astc_pkg::CMD_PRESS));
		repeat (4) begin
			case (shadow.edit_sel)
				astc_pkg::FLD_HOUR:   n = $urandom_range(0, 14);
				astc_pkg::FLD_MINUTE: n = ($urandom_range(0, 9) == 0) ?
				                          $urandom_range(55, 64) : $urandom_range(0, 6);
				astc_pkg::FLD_PM:     n = $urandom_range(0, 2);
				default:              n = force_arm ? (shadow.e_armed ? 0 : 1)
				                                    : $urandom_range(0, 3);
			endcase
			repeat (n) begin
				if (!force_arm && $urandom_range(0, 7) == 0)
					push_event(tick_beat());
				push_event(any_beat(knob_dir()));
			end
			push_event(any_beat(astc_pkg::CMD_PRESS));
		end
	endtask

	task automatic settle_quiet();
		if (shadow.ringing)
			push_event(any_beat(astc_pkg::CMD_PRESS));
		while (shadow.in_edit)
			push_event(any_beat(astc_pkg::CMD_PRESS));
	endtask

	// arm, fire, let it ring for len ticks, silence
	task automatic hold_alarm(input int len);
		settle_quiet();
		set_sequence(1'b1);
		push_event(mk(astc_pkg::CMD_TICK, shadow.al_hour, shadow.al_min));
		repeat (len) push_event(any_beat(astc_pkg::CMD_TICK));
		push_event(any_beat(astc_pkg::CMD_PRESS));
	endtask

	task automatic random_run(input int unsigned quota);
		int pick;
		int n;
		phase_items = 0;
		while (phase_items < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				set_sequence(1'b0);
			end else if (pick < 70) begin
				n = $urandom_range(1, 40);
				repeat (n) push_event(tick_beat());
			end else if (pick < 80) begin
				push_event(any_beat(astc_pkg::CMD_PRESS));
			end else begin
				push_event(any_beat(astc_pkg::cmd_t'($urandom_range(0, 3))));
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: knobs ignored, 12 am commit, wraps, 12 pm commit
		push_event(mk(astc_pkg::CMD_TICK, 5'd0, 6'd0));
		push_event(mk(astc_pkg::CMD_CW, 5'd23, 6'd59));
		push_event(mk(astc_pkg::CMD_CCW, 5'd0, 6'd0));
		repeat (5) push_event(mk(astc_pkg::CMD_PRESS, 5'd31, 6'd63));
		push_event(mk(astc_pkg::CMD_PRESS, 5'd0, 6'd0));
		push_event(mk(astc_pkg::CMD_CCW, 5'd12, 6'd30));
		push_event(mk(astc_pkg::CMD_CW, 5'd1, 6'd1));
		push_event(mk(astc_pkg::CMD_CW, 5'd2, 6'd2));
		push_event(mk(astc_pkg::CMD_CCW, 5'd3, 6'd3));
		push_event(mk(astc_pkg::CMD_PRESS, 5'd4, 6'd4));
		push_event(mk(astc_pkg::CMD_CCW, 5'd5, 6'd5));
		push_event(mk(astc_pkg::CMD_CW, 5'd6, 6'd6));
		push_event(mk(astc_pkg::CMD_CCW, 5'd7, 6'd7));
		push_event(mk(astc_pkg::CMD_PRESS, 5'd8, 6'd8));
		push_event(mk(astc_pkg::CMD_CW, 5'd16, 6'd16));
		push_event(mk(astc_pkg::CMD_PRESS, 5'd9, 6'd9));
		push_event(mk(astc_pkg::CMD_CCW, 5'd10, 6'd32));
		push_event(mk(astc_pkg::CMD_PRESS, 5'd11, 6'd11));
		// matching time, but still inside the lockout after reset
		push_event(mk(astc_pkg::CMD_TICK, 5'd12, 6'd59));
		push_event(mk(astc_pkg::CMD_TICK, 5'd31, 6'd63));

		set_regs(17'd1, 17'd0, 17'd0);
		random_run(120);
		hold_alarm(8);

		set_regs(17'd20, 17'd5, 17'd3);
		calm = 1'b1;
		random_run(160);
		calm = 1'b0;

		set_regs(17'd65535, 17'd0, 17'd4095);
		random_run(80);
		hold_alarm(20);
		// long idle with the timeout at its maximum, set mode must survive
		settle_quiet();
		push_event(mk(astc_pkg::CMD_PRESS, 5'd31, 6'd63));
		repeat (40) push_event(mk(astc_pkg::CMD_TICK, 5'd31, 6'd63));
		repeat (4) push_event(mk(astc_pkg::CMD_PRESS, 5'd31, 6'd63));

		set_regs(17'd3, 17'd131071, 17'd10);
		random_run(80);

		set_regs(17'($urandom_range(1, 200)), 17'($urandom_range(0, 300)),
		         17'($urandom_range(0, 4095)));
		random_run(120);

		drain();
		$display("covered %0d events and %0d results over five register settings",
		         events_sent, shadow.seen);
		$display("alarms fired %0d, track restarts %0d, silenced %0d, commits %0d, timeouts %0d",
		         shadow.fires, shadow.restarts, shadow.stops, shadow.commits,
		         shadow.timeouts);
		if (shadow.errors == 0)
			$display("tb_alarm_set_and_trigger_controller_core OK");
		else
			$display("tb_alarm_set_and_trigger_controller_core NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
design/astc_pkg.sv
design/alarm_set_and_trigger_controller_core.sv
test/tb_alarm_set_and_trigger_controller_core.sv
